/* hw/rtl/ack_response_receiver_assert.svh */
// ============================================================================
// Assertion macros for the acknowledge reply receiver
// Concurrent checks that compile away when SYNTHESIS is defined.
// ============================================================================
`ifndef ACK_RESPONSE_RECEIVER_ASSERT_SVH
`define ACK_RESPONSE_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS
// Implication checked in the same cycle.
`define ARR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ack_response_receiver check failed");
// Implication checked in the next cycle.
`define ARR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ack_response_receiver check failed");
`else
`define ARR_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define ARR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/arr_pkg.sv */
// ============================================================================
// arr_pkg
// Shared codes, types and the CRC-16/ARC helper of the reply receiver.
// ============================================================================
`default_nettype none

package arr_pkg;

  // Framing characters and reply codes.
  localparam logic [7:0] CH_DLE    = 8'h10;
  localparam logic [7:0] CH_STX    = 8'h02;
  localparam logic [7:0] CH_ETX    = 8'h03;
  localparam logic [7:0] CODE_ACK  = 8'hAA;
  localparam logic [7:0] CODE_NACK = 8'h55;

  // CRC-16/ARC, polynomial 0x8005 in reflected form.
  localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

  // Reset values of the configuration registers.
  localparam logic [15:0] TIMEOUT_RESET = 16'd50;
  localparam logic [7:0]  MAX_ATT_RESET = 8'd3;

  // Item kinds on the input stream; code 3 is ignored.
  typedef enum logic [1:0] {
    FUNC_BYTE  = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_START = 2'd2
  } func_t;

  // Result events.
  typedef enum logic [2:0] {
    EV_ACK      = 3'd0,
    EV_NACK     = 3'd1,
    EV_BAD_CRC  = 3'd2,
    EV_BAD_SIZE = 3'd3,
    EV_TIMEOUT  = 3'd4,
    EV_GAVE_UP  = 3'd5
  } event_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_TIMEOUT = 1'b0,
    CFG_MAX_ATT = 1'b1
  } cfg_idx_t;

  // Deframer phases.
  typedef enum logic [1:0] {
    PH_WAIT_DLE  = 2'd0,
    PH_WAIT_STX  = 2'd1,
    PH_IN_FRAME  = 2'd2,
    PH_AFTER_DLE = 2'd3
  } phase_t;

  // Frame status handed from the deframer to the control logic.
  typedef struct packed {
    logic       done;
    logic       size_ok;
    logic       crc_ok;
    logic [7:0] code;
  } frame_t;

  // CRC-16/ARC of a single byte, starting from zero.
  function automatic logic [15:0] crc_arc_byte(input logic [7:0] b);
    logic [15:0] c;
    c = {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/arr_deframer.sv */
// ============================================================================
// arr_deframer
// DLE/STX/ETX deframer with DLE-DLE unescaping and a three-byte payload store.
// ============================================================================
`default_nettype none

module arr_deframer (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          byte_en,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          restart,
  output arr_pkg::frame_t    frame
);
  import arr_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [2:0] len;
  logic [2:0] len_next;
  logic       take;
  logic [7:0] store [3];

  // Next phase, length and payload capture.
  always_comb begin
    phase_next = phase;
    len_next   = len;
    take       = 1'b0;
    if (restart) begin
      phase_next = PH_WAIT_DLE;
      len_next   = 3'd0;
    end else if (byte_en) begin
      unique case (phase)
        PH_WAIT_DLE: begin
          if (rx_byte == CH_DLE) phase_next = PH_WAIT_STX;
        end
        PH_WAIT_STX: begin
          if (rx_byte == CH_STX) begin
            len_next   = 3'd0;
            phase_next = PH_IN_FRAME;
          end else if (rx_byte != CH_DLE) begin
            phase_next = PH_WAIT_DLE;
          end
        end
        PH_IN_FRAME: begin
          if (rx_byte == CH_DLE) phase_next = PH_AFTER_DLE;
          else                   take = 1'b1;
        end
        PH_AFTER_DLE: begin
          if (rx_byte == CH_ETX) begin
            phase_next = PH_WAIT_DLE;
            len_next   = 3'd0;
          end else if (rx_byte == CH_DLE) begin
            take       = 1'b1;
            phase_next = PH_IN_FRAME;
          end else begin
            phase_next = PH_WAIT_DLE;
          end
        end
      endcase
      // Length saturates at four.
      if (take && len < 3'd4) len_next = 3'(len + 3'd1);
    end
  end

  // Frame status at the closing DLE ETX, from the stored payload.
  always_comb begin
    frame.done    = byte_en && (phase == PH_AFTER_DLE) && (rx_byte == CH_ETX);
    frame.size_ok = (len == 3'd3);
    frame.crc_ok  = (crc_arc_byte(store[0]) == {store[1], store[2]});
    frame.code    = store[0];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT_DLE;
      len   <= 3'd0;
    end else begin
      phase <= phase_next;
      len   <= len_next;
    end
  end

  // Payload store, only the first three bytes are kept.
  always_ff @(posedge clk) begin
    if (take && len < 3'd3) store[len[1:0]] <= rx_byte;
  end

endmodule

`default_nettype wire

/* hw/rtl/ack_response_receiver.sv */
// ============================================================================
// ack_response_receiver
// Waits for an ACK/NACK reply frame, counts timeout ticks and resend attempts.
// ============================================================================
// Results: an input transfer is held in the input register, and its result in
// the output register until it is taken.
// Throughput: one item per cycle; the input register and the output register
// advance together, so a stalled result only blocks once both are full.
// Reset: synchronous; clears the wait, deframer and counters, and sets the configuration to its defaults.
`default_nettype none

module ack_response_receiver (
  input  wire logic                clk,
  input  wire logic                rst,
  // Input stream
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [7:0]          s_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]          s_tuser,   // [1:0] func
  // Result stream
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [7:0]               m_tdata,   // [7:0] attempt_number
  output logic [2:0]               m_tuser,   // [2:0] event_res
  // Configuration writes
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire arr_pkg::cfg_idx_t   cfg_index,
  input  wire logic [15:0]         cfg_data
);
  `include "ack_response_receiver_assert.svh"
  import arr_pkg::*;

  // Configuration registers.
  logic [15:0] timeout_ticks;
  logic [7:0]  max_attempts;

  // Input register.
  logic        in_valid;
  logic [1:0]  in_func;
  logic [7:0]  in_byte;

  // Wait state.
  logic        waiting;
  logic        waiting_next;
  logic [15:0] ticks;
  logic [15:0] ticks_next;
  logic [7:0]  attempts;
  logic [7:0]  attempts_next;

  // Per-item decision.
  logic        advance;
  logic        byte_en;
  logic        restart;
  logic        emit;
  event_t      ev;
  logic [7:0]  ev_att;
  logic [15:0] tick_inc;
  logic        resend;
  event_t      resend_ev;
  frame_t      frame;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      max_attempts  <= MAX_ATT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TIMEOUT: timeout_ticks <= cfg_data;
        CFG_MAX_ATT: max_attempts  <= cfg_data[7:0];
      endcase
    end
  end

  // Input register loads on every input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  arr_deframer u_deframer (
    .clk     (clk),
    .rst     (rst),
    .byte_en (byte_en),
    .rx_byte (in_byte),
    .restart (restart),
    .frame   (frame)
  );

  assign tick_inc = (ticks == 16'hFFFF) ? ticks : 16'(ticks + 16'd1);

  // Item handling: start, byte and tick.
  always_comb begin
    waiting_next  = waiting;
    ticks_next    = ticks;
    attempts_next = attempts;
    byte_en       = 1'b0;
    restart       = 1'b0;
    emit          = 1'b0;
    ev            = EV_ACK;
    ev_att        = attempts;
    resend        = 1'b0;
    resend_ev     = EV_NACK;
    if (advance) begin
      unique case (in_func)
        FUNC_START: begin
          restart    = 1'b1;
          ticks_next = 16'd0;
          if (max_attempts == 8'd0) begin
            waiting_next  = 1'b0;
            attempts_next = 8'd0;
            emit          = 1'b1;
            ev            = EV_GAVE_UP;
            ev_att        = 8'd0;
          end else begin
            attempts_next = 8'd1;
            waiting_next  = 1'b1;
          end
        end
        FUNC_BYTE: begin
          if (waiting) begin
            byte_en = 1'b1;
            if (frame.done) begin
              priority if (!frame.size_ok) begin
                emit = 1'b1;
                ev   = EV_BAD_SIZE;
              end else if (!frame.crc_ok) begin
                emit = 1'b1;
                ev   = EV_BAD_CRC;
              end else if (frame.code == CODE_ACK) begin
                emit         = 1'b1;
                ev           = EV_ACK;
                waiting_next = 1'b0;
              end else if (frame.code == CODE_NACK) begin
                resend    = 1'b1;
                resend_ev = EV_NACK;
              end else begin
                // A valid frame with another code lets the wait go on.
              end
            end
          end
        end
        FUNC_TICK: begin
          if (waiting) begin
            ticks_next = tick_inc;
            if (tick_inc >= timeout_ticks) begin
              resend    = 1'b1;
              resend_ev = EV_TIMEOUT;
            end
          end
        end
        default: begin
        end
      endcase

      // Resend while attempts remain, otherwise give up.
      if (resend) begin
        restart = 1'b1;
        emit    = 1'b1;
        if (attempts < max_attempts) begin
          attempts_next = 8'(attempts + 8'd1);
          ticks_next    = 16'd0;
          ev            = resend_ev;
        end else begin
          waiting_next = 1'b0;
          ev           = EV_GAVE_UP;
        end
      end
    end
  end

  // Wait state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      waiting  <= 1'b0;
      ticks    <= 16'd0;
      attempts <= 8'd0;
    end else begin
      waiting  <= waiting_next;
      ticks    <= ticks_next;
      attempts <= attempts_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      m_tuser <= ev;
      m_tdata <= ev_att;
    end
  end

  // A success or a give-up ends the wait.
  `ARR_ASSERT_NEXT(a_wait_ends, clk, rst, emit && (ev == EV_ACK || ev == EV_GAVE_UP), !waiting)
  // A resend clears the tick count.
  `ARR_ASSERT_NEXT(a_resend_clears_ticks, clk, rst, resend && ev != EV_GAVE_UP, ticks == 16'd0)
  // A held input item is not lost while the result side stalls.
  `ARR_ASSERT_NEXT(a_input_held, clk, rst, in_valid && !advance, in_valid)
  // Nothing is processed while a result waits and is not taken.
  `ARR_ASSERT_NOW(a_no_overrun, clk, rst, m_tvalid && !m_tready, !advance)

endmodule

`default_nettype wire

/* sim/arr_reply_checker.sv */
// ============================================================================
// Reply receiver checker
// Watches the input, result and configuration channels of the acknowledge
// reply receiver, predicts each result from its own model of the deframer,
// the CRC check and the attempt logic, and compares every result transfer
// field by field with the oldest prediction still waiting.
// ============================================================================

module arr_reply_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  input  wire logic       s_tready,
  input  wire logic [7:0] s_tdata,    // [7:0] rx_byte
  input  wire logic [1:0] s_tuser,    // [1:0] func
  input  wire logic       m_tvalid,
  input  wire logic       m_tready,
  input  wire logic [7:0] m_tdata,    // [7:0] attempt_number
  input  wire logic [2:0] m_tuser,    // [2:0] event_res
  input  wire logic       cfg_valid,
  input  wire logic       cfg_ready,
  input  wire arr_pkg::cfg_idx_t cfg_index,
  input  wire logic [15:0] cfg_data,
  output int              mismatches,
  output int              replies_outstanding,
  output int              items_acted,
  output int              results_seen
);
  import arr_pkg::*;

  // One predicted result; hit is low when the item causes none.
  typedef struct packed {
    logic       hit;
    event_t     ev;
    logic [7:0] att;
  } reply_t;

  // Model state and its copy of the configuration.
  logic        waiting;
  phase_t      phase;
  logic [7:0]  body [3];
  logic [2:0]  body_len;
  logic [15:0] ticks;
  logic [7:0]  attempts;
  logic [15:0] timeout_reg;
  logic [7:0]  max_att_reg;

  reply_t      awaited_events [$];
  reply_t      want;
  reply_t      fresh;
  int          err_count;
  int          acted_count;
  int          seen_count;

  // CRC-16/ARC of one byte: reflected, zero start, no final inversion.
  function automatic logic [15:0] arc16_of(input logic [7:0] b);
    logic [15:0] acc;
    logic        lsb;
    acc = {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      lsb = acc[0];
      acc = acc >> 1;
      if (lsb) acc = acc ^ CRC_POLY_REFL;
    end
    return acc;
  endfunction

  function automatic void reset_deframer();
    phase    = PH_WAIT_DLE;
    body_len = 3'd0;
  endfunction

  // Keep the first three payload bytes; the length saturates at four.
  function automatic void store_body(input logic [7:0] b);
    if (body_len < 3'd3) body[body_len[1:0]] = b;
    if (body_len < 3'd4) body_len = body_len + 3'd1;
  endfunction

  // NACK or timeout: resend while attempts remain, otherwise give up.
  function automatic reply_t retry_or_abandon(input event_t why);
    reply_t r;
    r.hit = 1'b1;
    r.att = attempts;
    if (attempts < max_att_reg) begin
      attempts = attempts + 8'd1;
      ticks    = 16'd0;
      r.ev     = why;
    end else begin
      waiting = 1'b0;
      r.ev    = EV_GAVE_UP;
    end
    reset_deframer();
    return r;
  endfunction

  // DLE ETX seen: size check, CRC check, then the reply code.
  function automatic reply_t close_frame();
    reply_t r;
    r.hit = 1'b0;
    r.ev  = EV_ACK;
    r.att = attempts;
    if (body_len != 3'd3) begin
      reset_deframer();
      r.hit = 1'b1;
      r.ev  = EV_BAD_SIZE;
    end else begin
      reset_deframer();
      if ({body[1], body[2]} != arc16_of(body[0])) begin
        r.hit = 1'b1;
        r.ev  = EV_BAD_CRC;
      end else if (body[0] == CODE_ACK) begin
        waiting = 1'b0;
        r.hit   = 1'b1;
        r.ev    = EV_ACK;
      end else if (body[0] == CODE_NACK) begin
        r = retry_or_abandon(EV_NACK);
      end
    end
    return r;
  endfunction

  // Deframer with DLE-DLE unescaping.
  function automatic reply_t take_byte(input logic [7:0] b);
    reply_t r;
    r.hit = 1'b0;
    r.ev  = EV_ACK;
    r.att = 8'd0;
    case (phase)
      PH_WAIT_DLE: begin
        if (b == CH_DLE) phase = PH_WAIT_STX;
      end
      PH_WAIT_STX: begin
        if (b == CH_STX) begin
          body_len = 3'd0;
          phase    = PH_IN_FRAME;
        end else if (b != CH_DLE) begin
          phase = PH_WAIT_DLE;
        end
      end
      PH_IN_FRAME: begin
        if (b == CH_DLE) phase = PH_AFTER_DLE;
        else store_body(b);
      end
      default: begin
        if (b == CH_ETX) begin
          r = close_frame();
        end else if (b == CH_DLE) begin
          store_body(CH_DLE);
          phase = PH_IN_FRAME;
        end else begin
          phase = PH_WAIT_DLE;
        end
      end
    endcase
    return r;
  endfunction

  // Advance the model by one input item.
  function automatic reply_t advance_receiver(input logic [1:0] kind, input logic [7:0] b);
    reply_t r;
    r.hit = 1'b0;
    r.ev  = EV_ACK;
    r.att = 8'd0;
    case (kind)
      FUNC_START: begin
        reset_deframer();
        ticks = 16'd0;
        if (max_att_reg == 8'd0) begin
          waiting  = 1'b0;
          attempts = 8'd0;
          r.hit    = 1'b1;
          r.ev     = EV_GAVE_UP;
        end else begin
          attempts = 8'd1;
          waiting  = 1'b1;
        end
      end
      FUNC_TICK: begin
        if (waiting) begin
          if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
          if (ticks >= timeout_reg) r = retry_or_abandon(EV_TIMEOUT);
        end
      end
      FUNC_BYTE: begin
        if (waiting) r = take_byte(b);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Results are compared before the same edge's input adds a prediction.
  always @(posedge clk) begin
    if (rst) begin
      waiting     = 1'b0;
      phase       = PH_WAIT_DLE;
      body_len    = 3'd0;
      ticks       = 16'd0;
      attempts    = 8'd0;
      timeout_reg = TIMEOUT_RESET;
      max_att_reg = MAX_ATT_RESET;
      awaited_events.delete();
      err_count   = 0;
      acted_count = 0;
      seen_count  = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen_count++;
        if (awaited_events.size() == 0) begin
          $display("%0t: expected no result, got event_res %0d attempt_number %0d",
                   $time, m_tuser, m_tdata);
          err_count++;
        end else begin
          want = awaited_events.pop_front();
          if (m_tuser != want.ev) begin
            $display("%0t: event_res expected %0d, got %0d", $time, want.ev, m_tuser);
            err_count++;
          end
          if (m_tdata != want.att) begin
            $display("%0t: attempt_number expected %0d, got %0d",
                     $time, want.att, m_tdata);
            err_count++;
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TIMEOUT: timeout_reg = cfg_data;
          CFG_MAX_ATT: max_att_reg = cfg_data[7:0];
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        if (s_tuser == FUNC_START ||
            (waiting && (s_tuser == FUNC_BYTE || s_tuser == FUNC_TICK)))
          acted_count++;
        fresh = advance_receiver(s_tuser, s_tdata);
        if (fresh.hit) awaited_events = {awaited_events, fresh};
      end
    end

    mismatches          <= err_count;
    replies_outstanding <= awaited_events.size();
    items_acted         <= acted_count;
    results_seen        <= seen_count;
  end

endmodule

/* sim/tb_ack_response_receiver.sv */
// ============================================================================
// Acknowledge reply receiver testbench
// Drives reply frames, timeout ticks and start items into the receiver with
// random gaps and random result stalls, walks through several timeout and
// attempt settings, and leaves all prediction and comparison to the checker.
// ============================================================================

module tb_ack_response_receiver;
  import arr_pkg::*;

  // The one func code the block has no name for; it is dropped.
  localparam logic [1:0] FUNC_SPARE   = 2'd3;
  localparam int         QUIET_CYCLES = 6;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'h00;      // [7:0] rx_byte
  logic [1:0]  s_tuser   = FUNC_BYTE;  // [1:0] func
  logic        m_tvalid;
  logic        m_tready  = 1'b1;
  logic [7:0]  m_tdata;                // [7:0] attempt_number
  logic [2:0]  m_tuser;                // [2:0] event_res
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CFG_TIMEOUT;
  logic [15:0] cfg_data  = 16'h0000;

  int          mismatches;
  int          replies_outstanding;
  int          items_acted;
  int          results_seen;

  logic        feed_steady  = 1'b0;  // sender never idles while set
  logic        drain_steady = 1'b0;  // result side starts no new stall while set
  int unsigned stall_left   = 0;
  int unsigned ready_roll;
  int          items_sent    = 0;
  int          settings_used = 0;
  logic [7:0]  frame_body [$];

  ack_response_receiver dut (.*);

  arr_reply_checker reply_chk (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Safety net far beyond the slowest correct run.
  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

  // Result side: mostly ready, short stalls, now and then a long one.
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (drain_steady || ready_roll < 70) begin
        m_tready <= 1'b1;
      end else if (ready_roll < 96) begin
        m_tready   <= 1'b0;
        stall_left <= $urandom_range(0, 2);
      end else begin
        m_tready   <= 1'b0;
        stall_left <= $urandom_range(8, 40);
      end
    end
  end

  function automatic int sender_gap();
    int unsigned roll;
    if (feed_steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One input transfer, after a random gap; tvalid stays up afterwards.
  task automatic send_item(input logic [1:0] kind, input logic [7:0] b);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // A reply frame. A three-byte body carries the code and its CRC (with one
  // bit flipped when corrupt); other sizes carry the code and random bytes.
  // Without a proper end the trailer is left off or broken.
  task automatic send_reply(input logic [7:0] code, input int len, input bit corrupt,
                            input bit proper_end);
    logic [15:0] crc;
    crc = crc_arc_byte(code);
    if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    frame_body.delete();
    if (len == 3) begin
      frame_body = {frame_body, code};
      frame_body = {frame_body, crc[15:8]};
      frame_body = {frame_body, crc[7:0]};
    end else begin
      for (int i = 0; i < len; i++) frame_body = {frame_body, (i == 0) ? code : 8'($urandom)};
    end
    send_item(FUNC_BYTE, CH_DLE);
    send_item(FUNC_BYTE, CH_STX);
    foreach (frame_body[i]) begin
      send_item(FUNC_BYTE, frame_body[i]);
      if (frame_body[i] == CH_DLE) send_item(FUNC_BYTE, CH_DLE);
    end
    if (proper_end) begin
      send_item(FUNC_BYTE, CH_DLE);
      send_item(FUNC_BYTE, CH_ETX);
    end else if ($urandom_range(0, 1) == 0) begin
      send_item(FUNC_BYTE, CH_DLE);
      send_item(FUNC_BYTE, 8'($urandom));
    end
  endtask

  // Stop sending and wait until every predicted result has been taken.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Registers change only with the block quiet; upper data bits are junk.
  task automatic apply_settings(input logic [15:0] tmo, input logic [7:0] max_att);
    settle();
    repeat (QUIET_CYCLES) @(posedge clk);
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_MAX_ATT, {8'($urandom), max_att});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // One random exchange: a start, a reply frame, ticks, noise or a spare code.
  task automatic random_exchange();
    int unsigned roll;
    int unsigned n;
    logic [7:0]  code;
    logic [7:0]  b;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      send_item(FUNC_START, 8'($urandom));
    end else if (roll < 57) begin
      n = $urandom_range(0, 99);
      code = (n < 40) ? CODE_ACK : (n < 75) ? CODE_NACK : 8'($urandom);
      send_reply(code, ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 6)) : 3,
                 $urandom_range(0, 4) == 0, $urandom_range(0, 9) != 0);
    end else if (roll < 79) begin
      n = $urandom_range(1, 6);
      repeat (n) send_item(FUNC_TICK, 8'($urandom));
    end else if (roll < 97) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: b = CH_DLE;
          1: b = CH_STX;
          2: b = CH_ETX;
          default: b = 8'($urandom);
        endcase
        send_item(FUNC_BYTE, b);
      end
    end else begin
      send_item(FUNC_SPARE, 8'($urandom));
    end
  endtask

  // One setting, then random traffic until enough items have been sent.
  task automatic run_phase(input logic [15:0] tmo, input logic [7:0] max_att,
                           input int quota);
    int goal;
    apply_settings(tmo, max_att);
    feed_steady  <= ($urandom_range(0, 3) == 0);
    drain_steady <= ($urandom_range(0, 3) == 0);
    goal = items_sent + quota;
    while (items_sent < goal) begin
      random_exchange();
      if ($urandom_range(0, 199) == 0) settle();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Nothing is waiting yet: ticks, bytes and the spare code are dropped.
    send_item(FUNC_TICK, 8'hFF);
    send_item(FUNC_BYTE, 8'h00);
    send_item(FUNC_SPARE, 8'hFF);
    // Attempt one answered by an ACK under the reset settings.
    send_item(FUNC_START, 8'h00);
    send_reply(CODE_ACK, 3, 1'b0, 1'b1);

    // Two attempts, two ticks: a NACK resends at once, then the second
    // attempt times out and the receiver gives up.
    apply_settings(16'd2, 8'd2);
    send_item(FUNC_START, 8'hFF);
    send_reply(CODE_NACK, 3, 1'b0, 1'b1);
    send_item(FUNC_SPARE, 8'h00);
    send_item(FUNC_TICK, 8'h00);
    send_item(FUNC_TICK, 8'hFF);
    // Wrong size, bad CRC, an unknown code whose frame needs unescaping,
    // a restart while waiting, and an ACK on the restarted wait.
    send_item(FUNC_START, 8'h00);
    send_reply(CODE_ACK, 1, 1'b0, 1'b1);
    send_reply(CODE_ACK, 3, 1'b1, 1'b1);
    send_reply(CH_DLE, 3, 1'b0, 1'b1);
    send_item(FUNC_START, 8'h00);
    send_reply(CODE_ACK, 3, 1'b0, 1'b1);

    // No attempts allowed and a zero timeout: a start gives up at once.
    apply_settings(16'd0, 8'd0);
    send_item(FUNC_START, 8'h55);

    // Random traffic over a spread of settings, extremes included.
    run_phase(16'd3, 8'd3, 250);
    run_phase(16'd1, 8'd1, 200);
    run_phase(16'hFFFF, 8'hFF, 200);
    run_phase(16'd0, 8'd2, 150);
    run_phase(16'd6, 8'hFF, 250);
    run_phase(16'd2, 8'd0, 40);
    run_phase(16'($urandom_range(1, 10)), 8'($urandom_range(1, 8)), 300);
    run_phase(16'($urandom_range(1, 65535)), 8'($urandom), 200);
    run_phase(16'($urandom_range(1, 20)), 8'($urandom_range(0, 255)), 250);
    run_phase(16'hFFFF, 8'd1, 150);

    settle();
    repeat (20) @(posedge clk);

    $display("Run covered %0d input transfers, %0d of them acted on, under %0d settings.",
             items_sent, items_acted, settings_used);
    $display("Replies, ticks, restarts and noise produced %0d compared results.",
             results_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
